// ===== hdl/qrs_pkg.sv =====
package qrs_pkg;

   localparam int COEF_W = 32;
   localparam int DISC_W = 66;              // |b*b - 4ac| stays below 2^66
   localparam int ROOT_W = DISC_W / 2;      // floor sqrt of the discriminant
   localparam int REM_W  = ROOT_W + 2;      // sqrt partial remainder
   localparam int MAG_W  = 34;              // |-b +/- s|
   localparam int DEN_W  = 33;              // 2 * |a|
   localparam int Q_W    = 32;              // quotient bits before saturation

   typedef enum logic [1:0] {
      KIND_DISTINCT,
      KIND_REPEAT,
      KIND_COMPLEX,
      KIND_DEGEN
   } kind_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
   } req_type;

   typedef struct packed {
      kind_type                 root_kind;
      logic signed [COEF_W-1:0] first_value;
      logic signed [COEF_W-1:0] second_value;
      logic                     saturated;
   } rsp_type;

   // per item facts carried beside the discriminant and root
   typedef struct packed {
      logic                     a_neg;
      logic                     a_zero;
      logic                     d_neg;
      logic                     d_zero;
      logic signed [COEF_W-1:0] b;
      logic [COEF_W-1:0]        ma;
   } side_type;

   // one divider stage: two lanes over a shared denominator
   typedef struct packed {
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem1;
      logic [DEN_W-1:0] rem2;
      logic [Q_W-1:0]   low1;
      logic [Q_W-1:0]   low2;
      logic [Q_W-1:0]   q1;
      logic [Q_W-1:0]   q2;
      logic             ovf1;
      logic             ovf2;
      logic             neg1;
      logic             neg2;
      kind_type         kind;
   } div_work_type;

endpackage

// ===== hdl/qrs_front.sv =====
module qrs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  qrs_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [qrs_pkg::DISC_W-1:0] out_disc,
   output qrs_pkg::side_type out_side
);
   import qrs_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic r1, r2, r3;

   logic [COEF_W-1:0] ma_ff, mb_ff, mc_ff, ma_in, mb_in, mc_in;
   logic              ac_neg_ff, ac_neg2_ff;
   side_type          side1_ff, side1_in, side2_ff, side3_ff, side3_in;
   logic [2*COEF_W-1:0] bb_ff, ac_ff, bb_in, ac_in;
   logic [DISC_W-1:0] disc_ff, disc_in, q4, bbx;
   logic [COEF_W-1:0] ua, ub, uc;

   assign r3 = !v3_ff || out_ready;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;

   // stage 1: magnitudes and signs
   always_comb begin
      ua = in_data.coef_a;
      ub = in_data.coef_b;
      uc = in_data.coef_c;
      ma_in = ua[COEF_W-1] ? (~ua + 1'b1) : ua;
      mb_in = ub[COEF_W-1] ? (~ub + 1'b1) : ub;
      mc_in = uc[COEF_W-1] ? (~uc + 1'b1) : uc;
      side1_in        = '0;
      side1_in.a_neg  = ua[COEF_W-1];
      side1_in.a_zero = (ua == '0);
      side1_in.b      = in_data.coef_b;
      side1_in.ma     = ma_in;
   end

   // stage 2: products
   assign bb_in = {{COEF_W{1'b0}}, mb_ff} * {{COEF_W{1'b0}}, mb_ff};
   assign ac_in = {{COEF_W{1'b0}}, ma_ff} * {{COEF_W{1'b0}}, mc_ff};

   // stage 3: discriminant magnitude and sign
   always_comb begin
      q4  = {ac_ff, 2'b00};
      bbx = {2'b00, bb_ff};
      side3_in = side2_ff;
      side3_in.d_neg = 1'b0;
      if (ac_neg2_ff) begin
         disc_in = bbx + q4;
      end else if (q4 <= bbx) begin
         disc_in = bbx - q4;
      end else begin
         disc_in = q4 - bbx;
         side3_in.d_neg = 1'b1;
      end
      side3_in.d_zero = (disc_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         ma_ff     <= ma_in;
         mb_ff     <= mb_in;
         mc_ff     <= mc_in;
         ac_neg_ff <= ua[COEF_W-1] ^ uc[COEF_W-1];
         side1_ff  <= side1_in;
      end
      if (r2) begin
         bb_ff      <= bb_in;
         ac_ff      <= ac_in;
         ac_neg2_ff <= ac_neg_ff;
         side2_ff   <= side1_ff;
      end
      if (r3) begin
         disc_ff  <= disc_in;
         side3_ff <= side3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_disc  = disc_ff;
   assign out_side  = side3_ff;

endmodule

// ===== hdl/qrs_sqrt.sv =====
module qrs_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [qrs_pkg::DISC_W-1:0] in_disc,
   input  qrs_pkg::side_type in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [qrs_pkg::ROOT_W-1:0] out_root,
   output qrs_pkg::side_type out_side
);
   import qrs_pkg::*;

   localparam int STG = DISC_W / 2;

   logic              valid_ff [STG];
   logic              stage_ready [STG];
   logic [REM_W-1:0]  rem_ff [STG];
   logic [REM_W-1:0]  rem_in [STG];
   logic [REM_W-1:0]  src_rem [STG];
   logic [ROOT_W-1:0] root_ff [STG];
   logic [ROOT_W-1:0] root_in [STG];
   logic [ROOT_W-1:0] src_root [STG];
   logic [DISC_W-1:0] rad_ff [STG];
   logic [DISC_W-1:0] src_rad [STG];
   side_type          side_ff [STG];
   side_type          src_side [STG];
   logic [REM_W+1:0]  cur [STG];
   logic [REM_W+1:0]  trial [STG];

   always_comb begin
      stage_ready[STG-1] = !valid_ff[STG-1] || out_ready;
      for (int k = STG - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end
   assign in_ready = stage_ready[0];

   // one root bit per stage from the next two radicand bits
   always_comb begin
      for (int k = 0; k < STG; k++) begin
         if (k == 0) begin
            src_rem[k]  = '0;
            src_root[k] = '0;
            src_rad[k]  = in_disc;
            src_side[k] = in_side;
         end else begin
            src_rem[k]  = rem_ff[k-1];
            src_root[k] = root_ff[k-1];
            src_rad[k]  = rad_ff[k-1];
            src_side[k] = side_ff[k-1];
         end
         cur[k]   = {src_rem[k], src_rad[k][DISC_W-1 -: 2]};
         trial[k] = {2'b00, src_root[k], 2'b01};
         if (cur[k] >= trial[k]) begin
            rem_in[k]  = REM_W'(cur[k] - trial[k]);
            root_in[k] = {src_root[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = REM_W'(cur[k]);
            root_in[k] = {src_root[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STG; k++) valid_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < STG; k++) begin
            if (stage_ready[k]) valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STG; k++) begin
         if (stage_ready[k]) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= src_rad[k] << 2;
            side_ff[k] <= src_side[k];
         end
      end
   end

   assign out_valid = valid_ff[STG-1];
   assign out_root  = root_ff[STG-1];
   assign out_side  = side_ff[STG-1];

endmodule

// ===== hdl/qrs_div.sv =====
module qrs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  qrs_pkg::div_work_type in_work,
   output logic                  out_valid,
   input  logic                  out_ready,
   output qrs_pkg::div_work_type out_work
);
   import qrs_pkg::*;

   localparam int STG = Q_W;

   logic         valid_ff [STG];
   logic         stage_ready [STG];
   div_work_type work_ff [STG];
   div_work_type work_in [STG];
   div_work_type src [STG];
   logic [DEN_W:0] cur1 [STG];
   logic [DEN_W:0] cur2 [STG];

   always_comb begin
      stage_ready[STG-1] = !valid_ff[STG-1] || out_ready;
      for (int k = STG - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end
   assign in_ready = stage_ready[0];

   // restoring division, one quotient bit per lane per stage
   always_comb begin
      for (int k = 0; k < STG; k++) begin
         src[k] = (k == 0) ? in_work : work_ff[k-1];
         work_in[k] = src[k];
         cur1[k] = {src[k].rem1, src[k].low1[Q_W-1]};
         cur2[k] = {src[k].rem2, src[k].low2[Q_W-1]};
         work_in[k].low1 = src[k].low1 << 1;
         work_in[k].low2 = src[k].low2 << 1;
         if (cur1[k] >= {1'b0, src[k].den}) begin
            work_in[k].rem1 = DEN_W'(cur1[k] - {1'b0, src[k].den});
            work_in[k].q1   = {src[k].q1[Q_W-2:0], 1'b1};
         end else begin
            work_in[k].rem1 = cur1[k][DEN_W-1:0];
            work_in[k].q1   = {src[k].q1[Q_W-2:0], 1'b0};
         end
         if (cur2[k] >= {1'b0, src[k].den}) begin
            work_in[k].rem2 = DEN_W'(cur2[k] - {1'b0, src[k].den});
            work_in[k].q2   = {src[k].q2[Q_W-2:0], 1'b1};
         end else begin
            work_in[k].rem2 = cur2[k][DEN_W-1:0];
            work_in[k].q2   = {src[k].q2[Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STG; k++) valid_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < STG; k++) begin
            if (stage_ready[k]) valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STG; k++) begin
         if (stage_ready[k]) work_ff[k] <= work_in[k];
      end
   end

   assign out_valid = valid_ff[STG-1];
   assign out_work  = work_ff[STG-1];

endmodule

// ===== hdl/quadratic_root_solver_core.sv =====
// quadratic root solver, fully pipelined
// req channel: one transaction carries coefficients a, b and c, signed q16.16
// rsp channel: one transaction per request, in order: root kind, two values and
//   a saturation flag
// a transaction moves on a rising edge where valid is high and stall is low
// a request passes through 3 front stages
//   (magnitudes, two 32x32 multipliers, discriminant), 33 square root stages
//   of one root bit each, 1 numerator stage, 32 divider stages of one
//   quotient bit each and the response register
// throughput is one transaction per cycle while rsp_stall stays low
// every stage has its own valid bit and loads whenever it is empty or the stage
//   after it moves, so bubbles close up while the receiver stalls
// while rsp_stall is high the pipeline fills up, and req_stall rises once no
//   empty stage is left; nothing is dropped or repeated
// reset clears every valid bit; the data registers are not reset
module quadratic_root_solver_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qrs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qrs_pkg::rsp_type rsp_data
);
   import qrs_pkg::*;

   // shifted numerator width
   localparam int NW = MAG_W + FRAC_BITS;

   logic              fr_ready, fr_valid, sq_ready, sq_valid;
   logic [DISC_W-1:0] fr_disc;
   side_type          fr_side, sq_side;
   logic [ROOT_W-1:0] sq_root;

   logic              prep_valid_ff, prep_ready;
   div_work_type      prep_ff, prep_in;
   logic              dv_ready, dv_valid;
   div_work_type      dv_work;

   logic              rsp_valid_ff, out_ready;
   rsp_type           rsp_ff, rsp_in;

   logic signed [MAG_W:0] nb, sx, num1, num2;
   logic [MAG_W-1:0]  mag1, mag2;
   logic [NW-1:0]     n1, n2;
   logic [DEN_W-1:0]  den;
   logic              big1, big2;
   logic [Q_W-1:0]    val1, val2;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign prep_ready = !prep_valid_ff || dv_ready;
   assign req_stall  = !fr_ready;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (fr_ready),
      .in_data   (req_data),
      .out_valid (fr_valid),
      .out_ready (sq_ready),
      .out_disc  (fr_disc),
      .out_side  (fr_side)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (sq_ready),
      .in_disc   (fr_disc),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_ready (prep_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // numerator stage: pick -b +/- s per root kind, split sign from magnitude
   // and check whether the quotient would need more than 32 bits
   always_comb begin
      nb = -(MAG_W + 1)'(sq_side.b);
      sx = $signed({2'b00, sq_root});
      den = {sq_side.ma, 1'b0};
      prep_in = '0;
      prep_in.den = den;
      if (sq_side.a_zero) begin
         prep_in.kind = KIND_DEGEN;
         num1 = nb;
         num2 = nb;
      end else if (sq_side.d_neg) begin
         // real part and imaginary part; the latter takes the sign of a
         prep_in.kind = KIND_COMPLEX;
         num1 = nb;
         num2 = sx;
      end else if (sq_side.d_zero) begin
         prep_in.kind = KIND_REPEAT;
         num1 = nb;
         num2 = nb;
      end else begin
         prep_in.kind = KIND_DISTINCT;
         num1 = nb + sx;
         num2 = nb - sx;
      end
      mag1 = num1[MAG_W] ? MAG_W'(-num1) : num1[MAG_W-1:0];
      mag2 = num2[MAG_W] ? MAG_W'(-num2) : num2[MAG_W-1:0];
      prep_in.neg1 = num1[MAG_W] ^ sq_side.a_neg;
      prep_in.neg2 = num2[MAG_W] ^ sq_side.a_neg;
      n1 = NW'(mag1) << FRAC_BITS;
      n2 = NW'(mag2) << FRAC_BITS;
      prep_in.ovf1 = (DEN_W'(n1[NW-1:Q_W]) >= den);
      prep_in.ovf2 = (DEN_W'(n2[NW-1:Q_W]) >= den);
      prep_in.rem1 = prep_in.ovf1 ? '0 : DEN_W'(n1[NW-1:Q_W]);
      prep_in.rem2 = prep_in.ovf2 ? '0 : DEN_W'(n2[NW-1:Q_W]);
      prep_in.low1 = n1[Q_W-1:0];
      prep_in.low2 = n2[Q_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (prep_ready) begin
         prep_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_ready) prep_ff <= prep_in;
   end

   qrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid_ff),
      .in_ready  (dv_ready),
      .in_work   (prep_ff),
      .out_valid (dv_valid),
      .out_ready (out_ready),
      .out_work  (dv_work)
   );

   // saturate each lane to the signed 32-bit range and apply its sign
   always_comb begin
      if (dv_work.neg1) begin
         big1 = dv_work.ovf1 || (dv_work.q1 > {1'b1, {(Q_W-1){1'b0}}});
         val1 = big1 ? {1'b1, {(Q_W-1){1'b0}}} : (~dv_work.q1 + 1'b1);
      end else begin
         big1 = dv_work.ovf1 || dv_work.q1[Q_W-1];
         val1 = big1 ? {1'b0, {(Q_W-1){1'b1}}} : dv_work.q1;
      end
      if (dv_work.neg2) begin
         big2 = dv_work.ovf2 || (dv_work.q2 > {1'b1, {(Q_W-1){1'b0}}});
         val2 = big2 ? {1'b1, {(Q_W-1){1'b0}}} : (~dv_work.q2 + 1'b1);
      end else begin
         big2 = dv_work.ovf2 || dv_work.q2[Q_W-1];
         val2 = big2 ? {1'b0, {(Q_W-1){1'b1}}} : dv_work.q2;
      end
      rsp_in.root_kind = dv_work.kind;
      if (dv_work.kind == KIND_DEGEN) begin
         // a is zero: values and flag forced to zero
         rsp_in.first_value  = '0;
         rsp_in.second_value = '0;
         rsp_in.saturated    = 1'b0;
      end else begin
         rsp_in.first_value  = $signed(val1);
         rsp_in.second_value = $signed(val2);
         rsp_in.saturated    = big1 || big2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.root_kind == KIND_DEGEN |->
         rsp_data.first_value == 0 && rsp_data.second_value == 0 && !rsp_data.saturated)
      else $error("degenerate response carries nonzero fields");

   a_repeat_same : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.root_kind == KIND_REPEAT |->
         rsp_data.first_value == rsp_data.second_value)
      else $error("repeated root values differ");

   a_no_stall_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import qrs_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 70;
   localparam int N_RANDOM = 680;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   quadratic_root_solver_core #(.FRAC_BITS(FRAC)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   req_type pending_coefs[$];
   rsp_type expected_roots[$];
   int      mismatch_count = 0;
   bit      stimulus_done = 1'b0;
   int      hold_cycles = 0;
   int      holds_done = 0;

   // floor square root of a value below 2^68
   function automatic logic [33:0] floor_sqrt(logic [67:0] v);
      logic [33:0] root;
      logic [33:0] cand;
      root = '0;
      for (int i = 33; i >= 0; i--) begin
         cand = root | (34'd1 << i);
         if (({34'd0, cand} * {34'd0, cand}) <= v) root = cand;
      end
      return root;
   endfunction

   // num * 2^FRAC / den truncated toward zero, clipped to 32 bits
   function automatic logic [31:0] scaled_quotient(logic [35:0] num, logic [32:0] den,
                                                   bit neg, ref bit sat);
      logic [67:0] q;
      q = ({32'd0, num} << FRAC) / {35'd0, den};
      if (neg) begin
         if (q > 68'h80000000) begin
            sat = 1'b1;
            q = 68'h80000000;
         end
         return 32'(-q);
      end
      if (q > 68'h7FFFFFFF) begin
         sat = 1'b1;
         q = 68'h7FFFFFFF;
      end
      return q[31:0];
   endfunction

   // signed numerator over 2a
   function automatic logic [31:0] over_two_a(logic signed [35:0] num, bit a_neg,
                                              logic [32:0] den, ref bit sat);
      logic [35:0] mag;
      mag = num < 0 ? 36'(-num) : 36'(num);
      return scaled_quotient(mag, den, (num < 0) != a_neg, sat);
   endfunction

   function automatic rsp_type solve_quadratic(req_type r);
      rsp_type res;
      logic signed [69:0] disc;
      logic [67:0] mag_disc;
      logic [33:0] s;
      logic [32:0] den;
      logic signed [35:0] neg_b;
      bit sat;
      bit a_neg;
      res = '0;
      sat = 1'b0;
      if (r.coef_a == 0) begin
         res.root_kind = KIND_DEGEN;
         return res;
      end
      a_neg = r.coef_a < 0;
      disc = 70'(r.coef_b) * 70'(r.coef_b) - 70'sd4 * 70'(r.coef_a) * 70'(r.coef_c);
      mag_disc = disc < 0 ? 68'(-disc) : 68'(disc);
      s = floor_sqrt(mag_disc);
      den = a_neg ? 33'(-34'(r.coef_a)) << 1 : 33'(r.coef_a) << 1;
      neg_b = -36'(r.coef_b);
      if (disc < 0) begin
         res.root_kind = KIND_COMPLEX;
         res.first_value = over_two_a(neg_b, a_neg, den, sat);
         res.second_value = scaled_quotient({2'b0, s}, den, a_neg, sat);
      end else if (disc == 0) begin
         res.root_kind = KIND_REPEAT;
         res.first_value = over_two_a(neg_b, a_neg, den, sat);
         res.second_value = res.first_value;
      end else begin
         res.root_kind = KIND_DISTINCT;
         res.first_value = over_two_a(neg_b + 36'(s), a_neg, den, sat);
         res.second_value = over_two_a(neg_b - 36'(s), a_neg, den, sat);
      end
      res.saturated = sat;
      return res;
   endfunction

   function automatic logic [31:0] random_coef();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
         2: return 32'($signed($urandom_range(0, 512)) - 256);
         3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         4: return 32'(($urandom_range(0, 64) - 32) << FRAC);
         default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      endcase
   endfunction

   task automatic queue_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      req_type r;
      r.coef_a = a;
      r.coef_b = b;
      r.coef_c = c;
      pending_coefs.push_back(r);
   endtask

   // fill the pending queue: directed corners first, then random coefficient sets
   initial begin
      logic [31:0] a;
      logic [31:0] k;
      queue_coefs(0, 32'h12345, 32'h777);                  // a zero, degenerate
      queue_coefs(0, 0, 0);
      queue_coefs(32'h10000, 32'hFFFD0000, 32'h20000);     // x^2-3x+2, distinct
      queue_coefs(32'h10000, 32'hFFFE0000, 32'h10000);     // repeated root 1
      queue_coefs(32'h10000, 0, 32'h10000);                // complex, a positive
      queue_coefs(32'hFFFF0000, 0, 32'hFFFF0000);          // complex, a negative
      queue_coefs(32'hFFFF0000, 32'h30000, 32'hFFFE0000);  // distinct, a negative
      queue_coefs(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      queue_coefs(32'h80000000, 32'h80000000, 32'h80000000);
      queue_coefs(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      queue_coefs(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      queue_coefs(1, 32'h7FFFFFFF, 0);                     // huge roots, saturated
      queue_coefs(1, 32'h80000000, 0);
      queue_coefs(32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      queue_coefs(1, 0, 32'h80000000);
      queue_coefs(32'h80000000, 0, 1);
      queue_coefs(32'hFFFFFFFF, 0, 32'hFFFFFFFF);
      queue_coefs(32'h10000, 0, 0);                        // zero discriminant at zero
      queue_coefs(32'h20000, 32'h1, 32'h0);
      queue_coefs(32'h55555555, 32'hAAAAAAAA, 32'h55555555);
      queue_coefs(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
      for (int i = 0; i < N_RANDOM; i++) begin
         a = random_coef();
         if ($urandom_range(0, 3) == 0) begin
            // repeated root: b = 2ak, c = ak^2 with small values
            a = 32'($signed($urandom_range(0, 64)) - 32);
            k = 32'($signed($urandom_range(0, 60)) - 30);
            queue_coefs(a << FRAC, (2 * a * k) << FRAC, (a * k * k) << FRAC);
         end else if ($urandom_range(0, 30) == 0) begin
            queue_coefs(0, random_coef(), random_coef());
         end else begin
            queue_coefs(a, random_coef(), random_coef());
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: random gap before each transaction, payload held while stalled
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_roots.push_back(solve_quadratic(req_data));
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0 || pending_coefs.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap > 0) send_gap--;
               if (pending_coefs.size() == 0 && !(req_valid && !req_stall) && !req_valid)
                  stimulus_done <= 1'b1;
            end else begin
               req_valid <= 1'b1;
               req_data <= pending_coefs.pop_front();
            end
         end
      end
   end

   // receiver stall: long hold-offs while the sender keeps offering items
   int stall_gap = 0;
   int rsp_count = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if ((holds_done == 0 && rsp_count >= 100) ||
                      (holds_done == 1 && rsp_count >= 400)) begin
            hold_cycles = 200;
            holds_done++;
            rsp_stall <= 1'b1;
         end else if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_valid && !rsp_stall)
               stall_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
         end
      end
   end

   // monitor: compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (expected_roots.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: %h", rsp_data);
         end else begin
            want = expected_roots.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: kind %0d/%0d first %h/%h second %h/%h sat %b/%b",
                           want.root_kind, rsp_data.root_kind, want.first_value,
                           rsp_data.first_value, want.second_value,
                           rsp_data.second_value, want.saturated, rsp_data.saturated);
            end
         end
      end
   end

   // end of run: drain, then keep watching for stray transactions before the verdict
   initial begin
      wait (stimulus_done);
      wait (expected_roots.size() == 0);
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
